@@ design/bmvp_pkg.sv @@
// Shared package of the banked memory and video plane controller.
// Holds sizes, operation and bank codes, latch bit positions and the queue types.
// No dependencies.
package bmvp_pkg;

  localparam int BANK_DEPTH   = 65536;
  localparam int ADDR_W       = $clog2(BANK_DEPTH);
  localparam int NUM_PAGES    = 8;
  localparam int PAGE_IDX_W   = $clog2(NUM_PAGES);
  localparam int PAGE_W       = ADDR_W - PAGE_IDX_W;
  localparam int PAGE_DEPTH   = BANK_DEPTH / NUM_PAGES;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [2:0] action_t;
  localparam action_t ACT_READ  = 3'd0;
  localparam action_t ACT_FETCH = 3'd1;
  localparam action_t ACT_WRITE = 3'd2;
  localparam action_t ACT_PORT  = 3'd3;
  localparam action_t ACT_PIXEL = 3'd4;
  localparam action_t ACT_LOAD  = 3'd5;

  typedef logic [2:0] op_kind_t;
  localparam op_kind_t OP_NOP   = 3'd0;
  localparam op_kind_t OP_READ  = 3'd1;
  localparam op_kind_t OP_FETCH = 3'd2;
  localparam op_kind_t OP_WRITE = 3'd3;
  localparam op_kind_t OP_BANK  = 3'd4;
  localparam op_kind_t OP_VIDEO = 3'd5;
  localparam op_kind_t OP_PIXEL = 3'd6;
  localparam op_kind_t OP_LOAD  = 3'd7;

  typedef logic [1:0] bank_t;
  localparam bank_t BANK_BASE  = 2'd0;
  localparam bank_t BANK_MAIN  = 2'd1;
  localparam bank_t BANK_BR    = 2'd2;
  localparam bank_t BANK_GREEN = 2'd3;

  localparam logic [15:0] PORT_ALIAS_MASK = 16'h207F;
  localparam logic [7:0]  PORT_BANK       = 8'h7F;
  localparam logic [7:0]  PORT_VIDEO      = 8'h80;

  localparam int BNK_MAIN_WR_N = 0;
  localparam int BNK_BR_WR     = 1;
  localparam int BNK_GREEN_WR  = 2;
  localparam int BNK_ROM_MAP_N = 4;
  localparam int BNK_RAM_MAP_N = 5;
  localparam int BNK_VID_MAP   = 6;
  localparam int VID_BR_OFF    = 2;
  localparam int VID_GREEN_OFF = 3;
  localparam int VID_GREEN_ALT = 4;
  localparam int MIRROR_BIT    = 14;

  localparam logic [PAGE_IDX_W-1:0] VIDEO_PAGE_LO = 3'd5;
  localparam logic [PAGE_IDX_W-1:0] VIDEO_PAGE_HI = 3'd6;

  typedef struct packed {
    bank_t                 bank;
    logic [PAGE_IDX_W-1:0] page;
  } map_entry_t;

  typedef map_entry_t [NUM_PAGES-1:0] page_map_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic [PAGE_W-1:0] poff;
    logic [2:0]        bit_idx;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } back_stat_t;

endpackage

@@ design/bmvp_front.sv @@
// Front end: accepts input beats and classifies them into queued operations.
// Decodes the action and the port number. Depends on bmvp_pkg.
module bmvp_front import bmvp_pkg::*; (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_action,
  input  logic [15:0]         in_address,
  input  logic [7:0]          in_data_in,
  input  logic [13:0]         in_pixel_offset,
  input  logic [2:0]          in_bit_index,
  input  queue_stat_t         q_stat,
  input  back_stat_t          back_stat,
  output logic                push,
  output op_t                 op
);

  logic port_is_bank;
  logic port_is_video;

  assign in_ready = !q_stat.full && !back_stat.clearing;
  assign push     = in_valid && in_ready;

  assign port_is_bank  = ((in_address & PORT_ALIAS_MASK) == PORT_ALIAS_MASK) ||
                         (in_address[7:0] == PORT_BANK);
  assign port_is_video = !port_is_bank && (in_address[7:0] == PORT_VIDEO);

  always_comb begin
    op.addr    = in_address;
    op.data    = in_data_in;
    op.poff    = in_pixel_offset[PAGE_W-1:0];
    op.bit_idx = in_bit_index;
    unique case (in_action)
      ACT_READ:  op.kind = OP_READ;
      ACT_FETCH: op.kind = OP_FETCH;
      ACT_WRITE: op.kind = OP_WRITE;
      ACT_PORT: begin
        if (port_is_bank) begin
          op.kind = OP_BANK;
        end else if (port_is_video) begin
          op.kind = OP_VIDEO;
        end else begin
          op.kind = OP_NOP;
        end
      end
      ACT_PIXEL: op.kind = OP_PIXEL;
      ACT_LOAD:  op.kind = OP_LOAD;
      default:   op.kind = OP_NOP;
    endcase
  end

endmodule

@@ design/bmvp_queue.sv @@
// Short queue of classified operations between the front and back ends.
// Depends on bmvp_pkg.
module bmvp_queue import bmvp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  op_t         op_in,
  input  logic        pop,
  output op_t         op_out,
  output queue_stat_t stat
);

  op_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign op_out     = slot_r[rd_ptr_r];
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

@@ design/bmvp_back.sv @@
// Back end: page maps, latches, the bank memories and the result register.
// Issues one queued operation a cycle while the output is not stalled, and clears the RAM banks after reset.
// Depends on bmvp_pkg.
module bmvp_back import bmvp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  queue_stat_t q_stat,
  input  op_t         q_op,
  output back_stat_t  stat,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [2:0]  out_colour
);

  function automatic page_map_t video_remap(page_map_t m, logic [7:0] vid);
    page_map_t             r;
    logic [PAGE_IDX_W-1:0] src;
    r = m;
    for (int p = 0; p < NUM_PAGES; p++) begin
      src = ((p & 2) != 0) ? VIDEO_PAGE_HI : VIDEO_PAGE_LO;
      if (!vid[VID_BR_OFF]) begin
        r[p] = {BANK_BR, src};
      end
      if (!vid[VID_GREEN_OFF]) begin
        r[p] = {BANK_GREEN, src};
      end
    end
    return r;
  endfunction

  logic [7:0]        base_mem  [BANK_DEPTH];
  logic [7:0]        main_mem  [BANK_DEPTH];
  logic [7:0]        br_lo_mem [PAGE_DEPTH];
  logic [7:0]        br_hi_mem [PAGE_DEPTH];
  logic [7:0]        gr_lo_mem [PAGE_DEPTH];
  logic [7:0]        gr_hi_mem [PAGE_DEPTH];

  page_map_t         rmap_r, rmap_nxt;
  page_map_t         fmap_r, fmap_nxt;
  logic [7:0]        bank_r, bank_nxt;
  logic [7:0]        vid_r, vid_nxt;
  logic              clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic              s1_valid_r, s1_valid_nxt;
  op_kind_t          s1_kind_r;
  bank_t             s1_bank_r;
  logic              s1_hi_r;
  logic [2:0]        s1_bit_r;
  logic [7:0]        s1_vid_r;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_read_data_r;
  logic [2:0]        out_colour_r;

  logic [7:0]        base_q_r, main_q_r, br_lo_q_r, br_hi_q_r, gr_lo_q_r, gr_hi_q_r;

  logic              issue;
  logic              s1_adv;
  map_entry_t        entry;
  logic [ADDR_W-1:0] bank_addr;
  logic [PAGE_W-1:0] plane_raddr;
  logic [PAGE_W-1:0] plane_waddr;
  logic              is_write;
  logic              main_we, br_we, gr_we;
  logic              br_lo_we, br_hi_we, gr_lo_we, gr_hi_we;
  logic [ADDR_W-1:0] main_waddr;
  logic [7:0]        plane_wdata;
  logic [7:0]        main_wdata;
  logic [7:0]        res_byte;
  logic [7:0]        green_byte;
  logic [7:0]        res_data;
  logic [2:0]        res_colour;

  assign s1_adv = s1_valid_r && (!out_valid_r || out_ready);
  assign issue  = !q_stat.empty && !clr_busy_r && (!s1_valid_r || s1_adv);

  assign stat.clearing = clr_busy_r;
  assign stat.pop      = issue;

  assign entry = (q_op.kind == OP_FETCH) ? fmap_r[q_op.addr[ADDR_W-1:PAGE_W]]
                                         : rmap_r[q_op.addr[ADDR_W-1:PAGE_W]];
  assign bank_addr   = {entry.page, q_op.addr[PAGE_W-1:0]};
  assign plane_raddr = (q_op.kind == OP_PIXEL) ? q_op.poff : q_op.addr[PAGE_W-1:0];

  assign is_write    = issue && (q_op.kind == OP_WRITE);
  assign main_we     = clr_busy_r || (is_write && !bank_r[BNK_MAIN_WR_N]);
  assign br_we       = is_write && bank_r[BNK_BR_WR] && !vid_r[VID_BR_OFF];
  assign gr_we       = is_write && bank_r[BNK_GREEN_WR] && !vid_r[VID_GREEN_OFF];
  assign br_lo_we    = clr_busy_r || (br_we && !q_op.addr[MIRROR_BIT]);
  assign br_hi_we    = clr_busy_r || (br_we && q_op.addr[MIRROR_BIT]);
  assign gr_lo_we    = clr_busy_r || (gr_we && !q_op.addr[MIRROR_BIT]);
  assign gr_hi_we    = clr_busy_r || (gr_we && q_op.addr[MIRROR_BIT]);
  assign main_waddr  = clr_busy_r ? clr_cnt_r : q_op.addr;
  assign main_wdata  = clr_busy_r ? 8'h00 : q_op.data;
  assign plane_waddr = clr_busy_r ? clr_cnt_r[PAGE_W-1:0] : q_op.addr[PAGE_W-1:0];
  assign plane_wdata = main_wdata;

  always_comb begin
    rmap_nxt     = rmap_r;
    fmap_nxt     = fmap_r;
    bank_nxt     = bank_r;
    vid_nxt      = vid_r;
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == '1) begin
        clr_busy_nxt = 1'b0;
      end
    end
    if (issue) begin
      unique case (q_op.kind)
        OP_BANK: begin
          bank_nxt = q_op.data;
          if (!q_op.data[BNK_RAM_MAP_N]) begin
            for (int p = 3; p <= 4; p++) begin
              rmap_nxt[p] = {BANK_MAIN, PAGE_IDX_W'(p)};
              fmap_nxt[p] = {BANK_MAIN, PAGE_IDX_W'(p)};
            end
          end
          if (q_op.data[BNK_VID_MAP]) begin
            rmap_nxt = video_remap(rmap_nxt, vid_r);
          end
          if (!q_op.data[BNK_ROM_MAP_N]) begin
            for (int p = 0; p <= 1; p++) begin
              rmap_nxt[p] = {BANK_BASE, PAGE_IDX_W'(p)};
              fmap_nxt[p] = {BANK_BASE, PAGE_IDX_W'(p)};
            end
          end
        end
        OP_VIDEO: begin
          vid_nxt = q_op.data;
          if (bank_r[BNK_VID_MAP]) begin
            rmap_nxt = video_remap(rmap_nxt, q_op.data);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (issue) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_PAGES; p++) begin
        rmap_r[p] <= {BANK_BASE, PAGE_IDX_W'(p)};
        fmap_r[p] <= {BANK_BASE, PAGE_IDX_W'(p)};
      end
      bank_r      <= '0;
      vid_r       <= '0;
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rmap_r      <= rmap_nxt;
      fmap_r      <= fmap_nxt;
      bank_r      <= bank_nxt;
      vid_r       <= vid_nxt;
      clr_busy_r  <= clr_busy_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_kind_r <= q_op.kind;
      s1_bank_r <= entry.bank;
      s1_hi_r   <= entry.page[1];
      s1_bit_r  <= q_op.bit_idx;
      s1_vid_r  <= vid_r;
    end
    if (s1_adv) begin
      out_read_data_r <= res_data;
      out_colour_r    <= res_colour;
    end
  end

  always_ff @(posedge clk) begin
    if (issue && (q_op.kind == OP_LOAD)) begin
      base_mem[q_op.addr] <= q_op.data;
    end
    if (issue) begin
      base_q_r <= base_mem[bank_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (main_we) begin
      main_mem[main_waddr] <= main_wdata;
    end
    if (issue) begin
      main_q_r <= main_mem[bank_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (br_lo_we) begin
      br_lo_mem[plane_waddr] <= plane_wdata;
    end
    if (issue) begin
      br_lo_q_r <= br_lo_mem[plane_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (br_hi_we) begin
      br_hi_mem[plane_waddr] <= plane_wdata;
    end
    if (issue) begin
      br_hi_q_r <= br_hi_mem[plane_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (gr_lo_we) begin
      gr_lo_mem[plane_waddr] <= plane_wdata;
    end
    if (issue) begin
      gr_lo_q_r <= gr_lo_mem[plane_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (gr_hi_we) begin
      gr_hi_mem[plane_waddr] <= plane_wdata;
    end
    if (issue) begin
      gr_hi_q_r <= gr_hi_mem[plane_raddr];
    end
  end

  always_comb begin
    unique case (s1_bank_r)
      BANK_BASE:  res_byte = base_q_r;
      BANK_MAIN:  res_byte = main_q_r;
      BANK_BR:    res_byte = s1_hi_r ? br_hi_q_r : br_lo_q_r;
      BANK_GREEN: res_byte = s1_hi_r ? gr_hi_q_r : gr_lo_q_r;
      default:    res_byte = main_q_r;
    endcase
    green_byte = s1_vid_r[VID_GREEN_ALT] ? gr_lo_q_r : gr_hi_q_r;
    res_data   = ((s1_kind_r == OP_READ) || (s1_kind_r == OP_FETCH)) ? res_byte : 8'h00;
    res_colour = 3'b000;
    if (s1_kind_r == OP_PIXEL) begin
      res_colour[2] = !s1_vid_r[VID_GREEN_OFF] && green_byte[s1_bit_r];
      res_colour[1] = !s1_vid_r[VID_BR_OFF] && br_hi_q_r[s1_bit_r];
      res_colour[0] = !s1_vid_r[VID_BR_OFF] && br_lo_q_r[s1_bit_r];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_colour    = out_colour_r;

endmodule

@@ design/banked_memory_and_video_plane_controller.sv @@
// Banked memory and video plane controller: front end, operation queue, back end.
// A result passes the queue slot, the stage-one registers and the output register in turn.
// Throughput: one beat per cycle while out_ready holds and no sweep runs, set by the single issue slot.
// Reset: synchronous; afterwards main RAM and the colour planes are swept to zero,
// one address a cycle, with in_ready held low throughout.
// Depends on bmvp_pkg, bmvp_front, bmvp_queue and bmvp_back.
module banked_memory_and_video_plane_controller import bmvp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_data_in,
  input  logic [13:0] in_pixel_offset,
  input  logic [2:0]  in_bit_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [2:0]  out_colour
);

  queue_stat_t q_stat;
  back_stat_t  back_stat;
  logic        push;
  op_t         front_op;
  op_t         q_op;

  bmvp_front u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_address      (in_address),
    .in_data_in      (in_data_in),
    .in_pixel_offset (in_pixel_offset),
    .in_bit_index    (in_bit_index),
    .q_stat          (q_stat),
    .back_stat       (back_stat),
    .push            (push),
    .op              (front_op)
  );

  bmvp_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .op_in  (front_op),
    .pop    (back_stat.pop),
    .op_out (q_op),
    .stat   (q_stat)
  );

  bmvp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .q_op          (q_op),
    .stat          (back_stat),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_colour    (out_colour)
  );

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.clearing |-> !in_ready)
    else $error("Input beat offered during the clearing sweep.");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !in_ready)
    else $error("Input ready while the queue is full.");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    back_stat.pop |-> !q_stat.empty)
    else $error("Back end issued from an empty queue.");

  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> back_stat.clearing)
    else $error("Clearing sweep did not start after reset.");

endmodule
